>>> rtl/core/dmrs_pkg.sv
package dmrs_pkg;

    // message limits and record layout
    localparam int MAX_MSG_BYTES = 65535;
    localparam int HEADER_LEN    = 12;
    localparam int QFIXED        = 4;
    localparam int RRFIXED       = 10;

    // top two bits of a name byte: both clear means a plain label
    localparam logic [1:0] LABEL_TAG = 2'b00;

    // result queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 8;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // result kinds
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // section codes
    localparam logic [1:0] SEC_QUESTION   = 2'd0;
    localparam logic [1:0] SEC_ANSWER     = 2'd1;
    localparam logic [1:0] SEC_AUTHORITY  = 2'd2;
    localparam logic [1:0] SEC_ADDITIONAL = 2'd3;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_MISMATCH = 3'd2,
        STAT_SHORT    = 3'd3,
        STAT_LONG     = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_NAME   = 4'd1,
        PH_LABEL  = 4'd2,
        PH_PTR2   = 4'd3,
        PH_FIXED  = 4'd4,
        PH_RDATA  = 4'd5,
        PH_DONE   = 4'd6,
        PH_TRAIL  = 4'd7,
        PH_EMPTY  = 4'd8
    } t_phase;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       is_last_byte;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] record_offset;
        logic [1:0]  section;
        logic [15:0] record_type;
        logic [15:0] record_class;
        logic [31:0] time_to_live;
        logic [15:0] rdata_length;
        logic [15:0] message_id;
        logic [15:0] header_flags;
        logic [2:0]  parse_status;
        logic        run_last;
    } t_result;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_result    item0;
        t_result    item1;
    } t_push;

    // parser state; lim holds the running sums of the section counts
    typedef struct packed {
        logic [15:0]      pos;
        logic [3:0][17:0] lim;
        logic [7:0]       hi;
        logic [17:0]      idx;
        logic [1:0]       sec;
        t_phase           phase;
        logic [15:0]      skip;
        logic [63:0]      shift;
        logic [15:0]      rdlen;
        logic [15:0]      start;
        logic [31:0]      idfl;
        logic             ovf;
    } t_pstate;

    localparam t_pstate PSTATE_RESET = '{
        pos:   16'd0,
        lim:   '0,
        hi:    8'd0,
        idx:   18'd0,
        sec:   SEC_QUESTION,
        phase: PH_HEADER,
        skip:  16'd0,
        shift: 64'd0,
        rdlen: 16'd0,
        start: 16'd0,
        idfl:  32'd0,
        ovf:   1'b0
    };

endpackage

>>> rtl/core/dmrs_parser.sv
module dmrs_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  dmrs_pkg::t_in_item i_item,
    output logic              o_pending,
    output dmrs_pkg::t_push   o_push
);
    import dmrs_pkg::*;

    // section of a record index against the running count sums
    function automatic logic [1:0] sec_of(input logic [17:0] idx,
                                          input logic [17:0] l0,
                                          input logic [17:0] l1,
                                          input logic [17:0] l2);
        logic [1:0] s;
        if (idx < l0) begin
            s = SEC_QUESTION;
        end else if (idx < l1) begin
            s = SEC_ANSWER;
        end else if (idx < l2) begin
            s = SEC_AUTHORITY;
        end else begin
            s = SEC_ADDITIONAL;
        end
        return s;
    endfunction

    logic       r_vld;
    logic [7:0] r_byte;
    logic       r_last;
    t_pstate    r_st;
    t_pstate    n_st;
    t_pstate    w_st;
    logic       w_emit;
    logic       w_next_rec;
    logic [15:0] w_cnt_word;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_byte <= i_item.msg_byte;
            r_last <= i_item.is_last_byte;
        end
    end

    assign o_pending  = r_vld;
    assign w_cnt_word = {r_st.hi, r_byte};

    // effect of one byte on the parse state
    always_comb begin
        w_st       = r_st;
        w_emit     = 1'b0;
        w_next_rec = 1'b0;
        if (r_st.pos >= 16'(MAX_MSG_BYTES)) begin
            w_st.ovf = 1'b1;
        end else begin
            case (r_st.phase)
                PH_HEADER: begin
                    if (r_st.pos < 16'd4) begin
                        w_st.idfl = r_st.idfl | (32'(r_byte) << {~r_st.pos[1:0], 3'b000});
                    end else begin
                        case (r_st.pos[3:0])
                            4'd5:  w_st.lim[0] = {2'b00, w_cnt_word};
                            4'd7:  w_st.lim[1] = r_st.lim[0] + {2'b00, w_cnt_word};
                            4'd9:  w_st.lim[2] = r_st.lim[1] + {2'b00, w_cnt_word};
                            4'd11: w_st.lim[3] = r_st.lim[2] + {2'b00, w_cnt_word};
                            default: w_st.hi = r_byte;
                        endcase
                    end
                    if (r_st.pos == 16'(HEADER_LEN - 1)) begin
                        if (w_st.lim[3] == 18'd0) begin
                            w_st.phase = PH_EMPTY;
                        end else begin
                            w_st.phase = PH_NAME;
                            w_st.start = 16'(HEADER_LEN);
                            w_st.sec   = sec_of(18'd0, r_st.lim[0], r_st.lim[1],
                                                r_st.lim[2]);
                        end
                    end
                end
                PH_NAME: begin
                    if (r_byte == 8'd0) begin
                        w_st.phase = PH_FIXED;
                        w_st.shift = 64'd0;
                        w_st.rdlen = 16'd0;
                        w_st.skip  = (r_st.sec == SEC_QUESTION) ? 16'(QFIXED)
                                                                : 16'(RRFIXED);
                    end else if (r_byte[7:6] != LABEL_TAG) begin
                        w_st.phase = PH_PTR2;
                    end else begin
                        w_st.skip  = {8'd0, r_byte};
                        w_st.phase = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    w_st.skip = r_st.skip - 16'd1;
                    if (w_st.skip == 16'd0) begin
                        w_st.phase = PH_NAME;
                    end
                end
                PH_PTR2: begin
                    w_st.phase = PH_FIXED;
                    w_st.shift = 64'd0;
                    w_st.rdlen = 16'd0;
                    w_st.skip  = (r_st.sec == SEC_QUESTION) ? 16'(QFIXED)
                                                            : 16'(RRFIXED);
                end
                PH_FIXED: begin
                    if (r_st.sec != SEC_QUESTION && r_st.skip <= 16'd2) begin
                        w_st.rdlen = {r_st.rdlen[7:0], r_byte};
                    end else begin
                        w_st.shift = {r_st.shift[55:0], r_byte};
                    end
                    w_st.skip = r_st.skip - 16'd1;
                    if (w_st.skip == 16'd0) begin
                        w_emit = 1'b1;
                        if (r_st.sec == SEC_QUESTION) begin
                            w_next_rec = 1'b1;
                        end else begin
                            w_st.skip = w_st.rdlen;
                            if (w_st.rdlen == 16'd0) begin
                                w_next_rec = 1'b1;
                            end else begin
                                w_st.phase = PH_RDATA;
                            end
                        end
                    end
                end
                PH_RDATA: begin
                    w_st.skip = r_st.skip - 16'd1;
                    if (w_st.skip == 16'd0) begin
                        w_next_rec = 1'b1;
                    end
                end
                PH_DONE: begin
                    w_st.phase = PH_TRAIL;
                end
                default: begin
                end
            endcase

            // move on to the next record or finish the walk
            if (w_next_rec) begin
                w_st.idx = r_st.idx + 18'd1;
                if (w_st.idx >= r_st.lim[3]) begin
                    w_st.phase = PH_DONE;
                end else begin
                    w_st.phase = PH_NAME;
                    w_st.start = r_st.pos + 16'd1;
                    w_st.sec   = sec_of(w_st.idx, r_st.lim[0], r_st.lim[1], r_st.lim[2]);
                end
            end
            w_st.pos = r_st.pos + 16'd1;
        end
    end

    // next state: the last byte returns the parser to its reset state
    always_comb begin
        if (!r_vld) begin
            n_st = r_st;
        end else if (r_last) begin
            n_st = PSTATE_RESET;
        end else begin
            n_st = w_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= PSTATE_RESET;
        end else begin
            r_st <= n_st;
        end
    end

    // results of this byte
    always_comb begin
        t_result desc;
        t_result stat;
        t_status st;

        desc               = '0;
        desc.result_kind   = KIND_RECORD;
        desc.record_offset = r_st.start;
        desc.section       = r_st.sec;
        if (r_st.sec == SEC_QUESTION) begin
            desc.record_type  = w_st.shift[31:16];
            desc.record_class = w_st.shift[15:0];
        end else begin
            desc.record_type  = w_st.shift[63:48];
            desc.record_class = w_st.shift[47:32];
            desc.time_to_live = w_st.shift[31:0];
            desc.rdata_length = w_st.rdlen;
        end
        desc.message_id   = w_st.idfl[31:16];
        desc.header_flags = w_st.idfl[15:0];
        desc.parse_status = STAT_OK;
        desc.run_last     = !r_last;

        if (w_st.ovf) begin
            st = STAT_LONG;
        end else begin
            case (w_st.phase)
                PH_HEADER: st = STAT_SHORT;
                PH_EMPTY:  st = STAT_EMPTY;
                PH_DONE:   st = STAT_OK;
                PH_TRAIL:  st = STAT_MISMATCH;
                default:   st = STAT_SHORT;
            endcase
        end
        stat              = '0;
        stat.result_kind  = KIND_STATUS;
        stat.message_id   = w_st.idfl[31:16];
        stat.header_flags = w_st.idfl[15:0];
        stat.parse_status = st;
        stat.run_last     = 1'b1;

        o_push       = '0;
        o_push.item0 = desc;
        o_push.item1 = stat;
        if (r_vld) begin
            if (w_emit) begin
                o_push.cnt = r_last ? 2'd2 : 2'd1;
            end else if (r_last) begin
                o_push.cnt   = 2'd1;
                o_push.item0 = stat;
            end
        end
    end

endmodule

>>> rtl/core/dmrs_out_queue.sv
module dmrs_out_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dmrs_pkg::t_push               i_push,
    input  logic                          i_pop,
    output logic                          o_valid,
    output dmrs_pkg::t_result             o_item,
    output logic [dmrs_pkg::Q_CNT_W-1:0]  o_count
);
    import dmrs_pkg::*;

    t_result              r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   r_head;
    logic [Q_PTR_W-1:0]   r_tail;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_PTR_W-1:0]   n_head;
    logic [Q_PTR_W-1:0]   n_tail;
    logic [Q_CNT_W-1:0]   n_count;
    logic [Q_PTR_W-1:0]   w_tail1;
    logic                 w_pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_head];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_pop;
    assign w_tail1 = r_tail + Q_PTR_W'(1);

    // pointer and fill count update
    always_comb begin
        n_tail  = r_tail + Q_PTR_W'(i_push.cnt);
        n_head  = w_pop ? r_head + Q_PTR_W'(1) : r_head;
        n_count = r_count + Q_CNT_W'(i_push.cnt) - Q_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_tail] <= i_push.item0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_tail1] <= i_push.item1;
        end
    end

endmodule

>>> rtl/core/dns_message_record_scanner_core.sv
// DNS message record scanner. Takes one message byte per item, in wire order,
// with the final byte marked, and can take a new byte in every cycle. Each
// byte goes through an input register and one parse step; the results it
// causes (a record descriptor when a question's or resource record's fixed
// fields complete, and an end-of-message status on the marked last byte) are
// written into an eight-entry result queue in the cycle after the byte is
// taken, and leave it one per cycle unless stalled. Input ready drops only
// when the queue could not hold the results of the byte in flight and of one
// more byte, which happens only while the output side is stalled. The header
// id and flags are given high byte first; ttl is the full 32 bits. After the
// last byte the scanner is back in its reset state for the next message.
module dns_message_record_scanner_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dmrs_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dmrs_pkg::t_result   o_out_item
);
    import dmrs_pkg::*;

    logic                 w_accept;
    logic                 w_pending;
    t_push                w_push;
    logic [Q_CNT_W-1:0]   w_q_count;
    logic [Q_CNT_W:0]     w_q_need;

    // room for the byte in flight and one more, two results each
    assign w_q_need   = {1'b0, w_q_count}
                        + (w_pending ? (Q_CNT_W + 1)'(4) : (Q_CNT_W + 1)'(2));
    assign o_in_ready = (w_q_need <= (Q_CNT_W + 1)'(QUEUE_DEPTH));
    assign w_accept   = i_in_valid && o_in_ready;

    dmrs_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_item    (i_in_item),
        .o_pending (w_pending),
        .o_push    (w_push)
    );

    dmrs_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .o_count (w_q_count)
    );

    // queue never fills past its depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= Q_CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // results are written only for a byte taken on the previous edge
    a_push_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt != 2'd0) |-> $past(i_in_valid && o_in_ready))
        else $error("results without an accepted item");

    // a pair of results is a descriptor followed by the closing status
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt == 2'd2) |-> (w_push.item1.result_kind == KIND_STATUS
                                  && w_push.item1.run_last
                                  && !w_push.item0.run_last
                                  && w_push.item0.result_kind == KIND_RECORD))
        else $error("bad result pair");

    // no result offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result offered after reset");

endmodule
